@@ rtl/gcf_pkg.sv @@
// ----------------------------------------------------------------------------
// gcf_pkg
// Shared types and constants of the glyph cache: field widths, register
// indexes, result status codes, engine states and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package gcf_pkg;

    localparam int CACHE_SLOTS_DEF     = 8;
    localparam int MAX_GLYPH_BYTES_DEF = 64;
    localparam int MIN_GLYPH_BYTES     = 32;

    localparam int CP_W       = 16;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;
    localparam int LEN_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_FONT_READY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_BYTES = CFG_IDX_W'(1);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 2'd0,
        ST_MISS      = 2'd1,
        ST_NOT_READY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_STREAM,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic             font_ready;
        logic [LEN_W-1:0] glyph_len;   // already saturated to the legal range
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/gcf_if.sv @@
// ----------------------------------------------------------------------------
// gcf_if
// Channel interfaces of the glyph cache: request, result and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcf_req_if
    import gcf_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            operation;
    logic [CP_W-1:0] code_point;
    logic [BYTE_W-1:0] fill_byte;

    modport source (output valid, operation, code_point, fill_byte, input ready);
    modport sink   (input valid, operation, code_point, fill_byte, output ready);
endinterface

interface gcf_rsp_if
    import gcf_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data_byte;
    logic [POS_W-1:0]    byte_position;
    logic                last;

    modport source (output valid, status, data_byte, byte_position, last, input ready);
    modport sink   (input valid, status, data_byte, byte_position, last, output ready);
endinterface

interface gcf_cfg_if
    import gcf_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/gcf_ram.sv @@
// ----------------------------------------------------------------------------
// gcf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module gcf_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/gcf_engine.sv @@
// ----------------------------------------------------------------------------
// gcf_engine
// Cache engine: tag and bitmap memories, valid marks, replacement pointer,
// fill writes, tag scan, bitmap streaming and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gcf_engine
    import gcf_pkg::*;
#(
    parameter int CACHE_SLOTS     = CACHE_SLOTS_DEF,
    parameter int MAX_GLYPH_BYTES = MAX_GLYPH_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg_in,
    gcf_req_if.sink          req,
    gcf_rsp_if.source        rsp
);

    localparam int SLOT_W   = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int CNT_W    = SLOT_W + 1;
    localparam int BM_DEPTH = CACHE_SLOTS * MAX_GLYPH_BYTES;
    localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(CACHE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  SLOT_COUNT = CNT_W'(CACHE_SLOTS);

    state_t state_reg, state_next;

    logic [CACHE_SLOTS-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]      next_slot_reg, next_slot_next;
    logic [POS_W-1:0]       fill_pos_reg, fill_pos_next;

    logic [CP_W-1:0]   cp_reg, cp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0] chk_idx_reg, chk_idx_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    status_t           pend_status_reg, pend_status_next;

    logic [LEN_W-1:0]  iss_pos_reg, iss_pos_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [POS_W-1:0]  dat_pos_reg, dat_pos_next;

    logic              out_vld_reg, out_vld_next;
    status_t           out_status_reg, out_status_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;

    logic              acc, fill_acc, lookup_acc, fill_done;
    logic              out_free, hit, scan_end, issue, move, stream_done;

    logic              tag_we, tag_re;
    logic [CP_W-1:0]   tag_rdata;
    logic [SLOT_W-1:0] tag_raddr;
    logic              bm_we, bm_re;
    logic [BM_AW-1:0]  bm_waddr, bm_raddr;
    logic [BYTE_W-1:0] bm_rdata;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    gcf_ram #(
        .WIDTH (CP_W),
        .DEPTH (CACHE_SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (next_slot_reg),
        .wdata (req.code_point),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    gcf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BM_DEPTH)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (req.fill_byte),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // ------------------------------------------------------------------
    // Handshake and shared conditions
    // ------------------------------------------------------------------
    assign req.ready  = (state_reg == S_IDLE);
    assign acc        = req.valid && req.ready;
    assign fill_acc   = acc && (req.operation == OP_FILL);
    assign lookup_acc = acc && (req.operation == OP_LOOKUP);
    assign fill_done  = ({1'b0, fill_pos_reg} + LEN_W'(1)) >= cfg_in.glyph_len;

    assign out_free   = !out_vld_reg || rsp.ready;

    assign hit        = chk_vld_reg && valid_reg[chk_idx_reg] && (tag_rdata == cp_reg);
    assign scan_end   = chk_vld_reg && !hit && (chk_idx_reg == LAST_SLOT);

    assign move        = rd_vld_reg && out_free;
    assign issue       = (iss_pos_reg < cfg_in.glyph_len) && (!rd_vld_reg || move);
    assign stream_done = move && (({1'b0, dat_pos_reg} + LEN_W'(1)) == cfg_in.glyph_len);

    assign tag_we    = fill_acc && fill_done;
    assign tag_re    = (state_reg == S_SCAN) && (cnt_reg < SLOT_COUNT);
    assign tag_raddr = cnt_reg[SLOT_W-1:0];

    assign bm_we    = fill_acc;
    assign bm_waddr = BM_AW'(next_slot_reg) * BM_AW'(MAX_GLYPH_BYTES) + BM_AW'(fill_pos_reg);
    assign bm_re    = (state_reg == S_STREAM) && issue;
    assign bm_raddr = BM_AW'(slot_reg) * BM_AW'(MAX_GLYPH_BYTES)
                      + BM_AW'(iss_pos_reg[POS_W-1:0]);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (lookup_acc)
                begin
                    state_next = cfg_in.font_ready ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_STREAM;
                end
                else if (scan_end)
                begin
                    state_next = S_RESULT;
                end
            end
            S_STREAM:
            begin
                if (stream_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        valid_next       = valid_reg;
        next_slot_next   = next_slot_reg;
        fill_pos_next    = fill_pos_reg;
        cp_next          = cp_reg;
        cnt_next         = cnt_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = chk_idx_reg;
        slot_next        = slot_reg;
        pend_status_next = pend_status_reg;
        iss_pos_next     = iss_pos_reg;
        rd_vld_next      = rd_vld_reg;
        dat_pos_next     = dat_pos_reg;
        out_vld_next     = out_vld_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_data_next    = out_data_reg;
        out_pos_next     = out_pos_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (fill_acc)
                begin
                    // first byte of a glyph invalidates the victim slot
                    if (fill_pos_reg == '0)
                    begin
                        valid_next[next_slot_reg] = 1'b0;
                    end
                    if (fill_done)
                    begin
                        valid_next[next_slot_reg] = 1'b1;
                        next_slot_next = (next_slot_reg == LAST_SLOT) ? '0
                                         : next_slot_reg + SLOT_W'(1);
                        fill_pos_next  = '0;
                    end
                    else
                    begin
                        fill_pos_next = fill_pos_reg + POS_W'(1);
                    end
                end
                if (lookup_acc)
                begin
                    cp_next          = req.code_point;
                    cnt_next         = '0;
                    pend_status_next = ST_NOT_READY;
                end
            end
            S_SCAN:
            begin
                // one tag read per cycle, compared in the following cycle
                if (tag_re)
                begin
                    cnt_next     = cnt_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg[SLOT_W-1:0];
                end
                if (hit)
                begin
                    chk_vld_next = 1'b0;
                    slot_next    = chk_idx_reg;
                    iss_pos_next = '0;
                    rd_vld_next  = 1'b0;
                end
                pend_status_next = ST_MISS;
            end
            S_STREAM:
            begin
                if (issue)
                begin
                    iss_pos_next = iss_pos_reg + LEN_W'(1);
                    dat_pos_next = iss_pos_reg[POS_W-1:0];
                    rd_vld_next  = 1'b1;
                end
                else if (move)
                begin
                    rd_vld_next = 1'b0;
                end
                if (move)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = ST_HIT;
                    out_data_next   = bm_rdata;
                    out_pos_next    = dat_pos_reg;
                    out_last_next   = stream_done;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = pend_status_reg;
                    out_data_next   = '0;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            next_slot_reg <= '0;
            fill_pos_reg  <= '0;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            iss_pos_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            next_slot_reg <= next_slot_next;
            fill_pos_reg  <= fill_pos_next;
            cnt_reg       <= cnt_next;
            chk_vld_reg   <= chk_vld_next;
            iss_pos_reg   <= iss_pos_next;
            rd_vld_reg    <= rd_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg          <= cp_next;
        chk_idx_reg     <= chk_idx_next;
        slot_reg        <= slot_next;
        pend_status_reg <= pend_status_next;
        dat_pos_reg     <= dat_pos_next;
        out_status_reg  <= out_status_next;
        out_data_reg    <= out_data_next;
        out_pos_reg     <= out_pos_next;
        out_last_reg    <= out_last_next;
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.data_byte     = out_data_reg;
    assign rsp.byte_position = out_pos_reg;
    assign rsp.last          = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/glyph_cache_fifo.sv @@
// Fill transaction: one bitmap byte per accepted request, no result.
// Lookup: tag scan over the tag RAM, one slot per cycle, until a hit or the
//   last slot; a hit then streams the clamped glyph length in bytes from the
//   bitmap RAM, one per cycle while the result channel is not stalled.
// Reset clears valid marks, pointers, font_ready (0) and glyph_bytes (32);
//   the tag and bitmap RAMs are not cleared.
// ----------------------------------------------------------------------------
// glyph_cache_fifo
// Fully associative glyph bitmap cache with round-robin replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_cache_fifo
    import gcf_pkg::*;
#(
    parameter int CACHE_SLOTS     = CACHE_SLOTS_DEF,
    parameter int MAX_GLYPH_BYTES = MAX_GLYPH_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gcf_req_if.sink    req,
    gcf_rsp_if.source  rsp,
    gcf_cfg_if.sink    cfg
);

    logic              font_ready_reg, font_ready_next;
    logic [LEN_W-1:0]  glyph_bytes_reg, glyph_bytes_next;
    cfg_t              cfg_bus;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        font_ready_next  = font_ready_reg;
        glyph_bytes_next = glyph_bytes_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FONT_READY:  font_ready_next  = cfg.data[0];
                REG_GLYPH_BYTES: glyph_bytes_next = cfg.data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_ready_reg  <= 1'b0;
            glyph_bytes_reg <= LEN_W'(MIN_GLYPH_BYTES);
        end
        else
        begin
            font_ready_reg  <= font_ready_next;
            glyph_bytes_reg <= glyph_bytes_next;
        end
    end

    // clamp the glyph length to the supported range
    always_comb
    begin
        cfg_bus.font_ready = font_ready_reg;
        priority if (glyph_bytes_reg < LEN_W'(MIN_GLYPH_BYTES))
        begin
            cfg_bus.glyph_len = LEN_W'(MIN_GLYPH_BYTES);
        end
        else if (glyph_bytes_reg > LEN_W'(MAX_GLYPH_BYTES))
        begin
            cfg_bus.glyph_len = LEN_W'(MAX_GLYPH_BYTES);
        end
        else
        begin
            cfg_bus.glyph_len = glyph_bytes_reg;
        end
    end

    gcf_engine #(
        .CACHE_SLOTS     (CACHE_SLOTS),
        .MAX_GLYPH_BYTES (MAX_GLYPH_BYTES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_in (cfg_bus),
        .req    (req),
        .rsp    (rsp)
    );

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_bus.glyph_len >= LEN_W'(MIN_GLYPH_BYTES))
        && (cfg_bus.glyph_len <= LEN_W'(MAX_GLYPH_BYTES)))
        else $error("glyph length out of range");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.operation == OP_LOOKUP)) |=> !req.ready)
        else $error("lookup did not block the request channel");

    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_HIT)) |-> (rsp.last && (rsp.data_byte == '0)))
        else $error("miss or not-ready result malformed");

    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_HIT))
        |-> (({1'b0, rsp.byte_position} < cfg_bus.glyph_len)
             && (rsp.last == (({1'b0, rsp.byte_position} + LEN_W'(1))
                              == cfg_bus.glyph_len))))
        else $error("hit byte position or last marker wrong");

endmodule

`default_nettype wire
